/* rtl/core/s27g_pkg.sv */
package s27g_pkg;

  localparam int SIZE_W   = 11;
  localparam int BETA_W   = 16;
  localparam int IDX_W    = 31;
  localparam int COEF_W   = 24;
  localparam int REG_IDX_W = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 88;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);
  localparam logic [BETA_W-1:0] BETA_RESET = BETA_W'(2048);

  // q12 coefficients
  localparam logic signed [COEF_W-1:0] COEF_DIAG = COEF_W'(106496);
  localparam logic signed [COEF_W-1:0] COEF_OFF  = -COEF_W'(4096);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2,
    REG_BETA   = 2'd3
  } reg_idx_t;

  // neighbour offset code along one axis
  typedef enum logic [1:0] {
    OFF_NEG = 2'd0,
    OFF_MID = 2'd1,
    OFF_POS = 2'd2
  } off_t;

  typedef struct packed {
    logic load;
    logic plane;
    logic zmul;
    logic sum;
    logic base;
    logic emit;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic cand_last;
  } dp_status_t;

endpackage

/* rtl/core/stencil27_matrix_row_generator.sv */
// one transaction in gives one matrix row of 1 to 27 entries; the next transaction is taken only
// once the last entry of the row has been issued. Setup runs load, plane, z multiply, row sum
// and base steps, then a serial scan of the 27 neighbour slots, one slot per cycle while the
// output is free, issues an entry for each slot inside the grid; the scan ends at the row's
// last valid slot, so 14 to 27 slots are scanned per row
// reset: synchronous, active high; point returns to zero, sizes to 16, beta to 0.5
module stencil27_matrix_row_generator #(
  parameter int DIM_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [s27g_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [s27g_pkg::BETA_W-1:0]         cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [s27g_pkg::IN_DATA_W-1:0]      s_tdata,   // restart
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [s27g_pkg::OUT_DATA_W-1:0]     m_tdata,   // row_index, col_index, coef
  output logic                                m_tlast,
  output logic [0:0]                          m_tuser    // grid_done
);
  import s27g_pkg::*;

  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic [BETA_W-1:0] skew_beta;
  dp_cmd_t           cmd;
  dp_status_t        status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x    <= SIZE_RESET;
      size_y    <= SIZE_RESET;
      size_z    <= SIZE_RESET;
      skew_beta <= BETA_RESET;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_SIZE_X: size_x    <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Y: size_y    <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Z: size_z    <= cfg_data[SIZE_W-1:0];
        REG_BETA:   skew_beta <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  s27g_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  s27g_dp #(
    .DIM_BITS (DIM_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .restart   (s_tdata[0]),
    .size_x    (size_x),
    .size_y    (size_y),
    .size_z    (size_z),
    .skew_beta (skew_beta),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

/* rtl/core/s27g_ctrl.sv */
module s27g_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  s27g_pkg::dp_status_t  status,
  output s27g_pkg::dp_cmd_t     cmd
);
  import s27g_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PLANE = 6'b000010,
    ST_ZMUL  = 6'b000100,
    ST_ROW   = 6'b001000,
    ST_BASE  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_PLANE;
        end
      end
      ST_PLANE: begin
        cmd.plane  = 1'b1;
        state_next = ST_ZMUL;
      end
      ST_ZMUL: begin
        cmd.zmul   = 1'b1;
        state_next = ST_ROW;
      end
      ST_ROW: begin
        cmd.sum    = 1'b1;
        state_next = ST_BASE;
      end
      ST_BASE: begin
        cmd.base   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.cand_last) begin
            cmd.advance = 1'b1;
            state_next  = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_emit_in_emit_state: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> state == ST_EMIT && !s_tready)
    else $error("emit issued outside emit state");

  a_accept_starts_setup: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_PLANE)
    else $error("accepted transaction did not start setup");

  a_advance_once: assert property (@(posedge clk) disable iff (rst)
    cmd.advance |=> !cmd.advance && !cmd.emit)
    else $error("point advanced twice for one row");

endmodule

/* rtl/core/s27g_dp.sv */
module s27g_dp #(
  parameter int DIM_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  s27g_pkg::dp_cmd_t                   cmd,
  output s27g_pkg::dp_status_t                status,
  input  logic                                restart,
  input  logic [s27g_pkg::SIZE_W-1:0]         size_x,
  input  logic [s27g_pkg::SIZE_W-1:0]         size_y,
  input  logic [s27g_pkg::SIZE_W-1:0]         size_z,
  input  logic [s27g_pkg::BETA_W-1:0]         skew_beta,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [s27g_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tlast,
  output logic [0:0]                          m_tuser
);
  import s27g_pkg::*;

  localparam int EW = DIM_BITS + 1;
  localparam int CW = (EW > SIZE_W) ? EW : SIZE_W;
  localparam logic [CW-1:0] LIM = CW'(1) << DIM_BITS;

  function automatic logic [EW-1:0] eff_size(input logic [SIZE_W-1:0] r);
    logic [CW-1:0] rw;
    rw = CW'(r);
    if (r == '0) begin
      eff_size = EW'(1);
    end else if (rw > LIM) begin
      eff_size = EW'(LIM);
    end else begin
      eff_size = EW'(rw);
    end
  endfunction

  function automatic logic axis_ok(input off_t off, input logic lo, input logic hi);
    case (off)
      OFF_NEG: axis_ok = lo;
      OFF_MID: axis_ok = 1'b1;
      OFF_POS: axis_ok = hi;
      default: axis_ok = 1'b0;
    endcase
  endfunction

  logic [DIM_BITS-1:0] px, py, pz;
  logic [EW-1:0]       nx, ny, nz;
  logic [EW-1:0]       nx_cfg, ny_cfg, nz_cfg;
  logic signed [BETA_W-1:0] beta;
  logic [IDX_W-1:0]    plane, yn, zp, row, base_m, base_p;
  logic                xlo, xhi, ylo, yhi, zlo, zhi;
  off_t                cdx, cdy, cdz;
  off_t                dxl, dyl, dzl;
  logic                outside;
  logic                cand_valid;
  logic                last_point;
  logic [IDX_W-1:0]    zsel, ysel, dsel, col;
  logic signed [COEF_W-1:0] beta_ext, coef;
  logic [IDX_W-1:0]    out_row, out_col;
  logic [COEF_W-1:0]   out_coef;
  logic                out_last, out_grid;

  assign nx_cfg = eff_size(size_x);
  assign ny_cfg = eff_size(size_y);
  assign nz_cfg = eff_size(size_z);
  assign outside = (EW'(px) >= nx_cfg) || (EW'(py) >= ny_cfg) || (EW'(pz) >= nz_cfg);

  // candidate neighbour checks
  assign cand_valid = axis_ok(cdx, xlo, xhi) && axis_ok(cdy, ylo, yhi) &&
                      axis_ok(cdz, zlo, zhi);
  assign dxl = xhi ? OFF_POS : OFF_MID;
  assign dyl = yhi ? OFF_POS : OFF_MID;
  assign dzl = zhi ? OFF_POS : OFF_MID;
  assign status.cand_last = (cdx == dxl) && (cdy == dyl) && (cdz == dzl);
  assign status.out_free  = !m_tvalid || m_tready;
  assign last_point = !xhi && !yhi && !zhi;

  always_comb begin
    case (cdz)
      OFF_NEG: zsel = base_m;
      OFF_POS: zsel = base_p;
      default: zsel = row;
    endcase
    case (cdy)
      OFF_NEG: ysel = '0 - IDX_W'(nx);
      OFF_POS: ysel = IDX_W'(nx);
      default: ysel = '0;
    endcase
    case (cdx)
      OFF_NEG: dsel = {IDX_W{1'b1}};
      OFF_POS: dsel = IDX_W'(1);
      default: dsel = '0;
    endcase
  end

  assign col = zsel + ysel + dsel;

  assign beta_ext = COEF_W'(beta);
  always_comb begin
    if (cdx == OFF_MID && cdy == OFF_MID) begin
      case (cdz)
        OFF_NEG: coef = COEF_OFF - beta_ext;
        OFF_POS: coef = COEF_OFF + beta_ext;
        default: coef = COEF_DIAG;
      endcase
    end else begin
      coef = COEF_OFF;
    end
  end

  // scan point
  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0;
      py <= '0;
      pz <= '0;
    end else if (cmd.load) begin
      if (restart || outside) begin
        px <= '0;
        py <= '0;
        pz <= '0;
      end
    end else if (cmd.advance) begin
      if (xhi) begin
        px <= px + DIM_BITS'(1);
      end else begin
        px <= '0;
        if (yhi) begin
          py <= py + DIM_BITS'(1);
        end else begin
          py <= '0;
          if (zhi) begin
            pz <= pz + DIM_BITS'(1);
          end else begin
            pz <= '0;
          end
        end
      end
    end
  end

  // row setup
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nx   <= nx_cfg;
      ny   <= ny_cfg;
      nz   <= nz_cfg;
      beta <= skew_beta;
    end
    if (cmd.plane) begin
      plane <= IDX_W'(nx) * IDX_W'(ny);
      yn    <= IDX_W'(py) * IDX_W'(nx);
      xlo   <= (px != '0);
      ylo   <= (py != '0);
      zlo   <= (pz != '0);
      xhi   <= (EW'(px) + EW'(1)) < nx;
      yhi   <= (EW'(py) + EW'(1)) < ny;
      zhi   <= (EW'(pz) + EW'(1)) < nz;
    end
    if (cmd.zmul) begin
      zp <= IDX_W'(pz) * plane;
    end
    if (cmd.sum) begin
      row <= zp + yn + IDX_W'(px) + IDX_W'(1);
    end
    if (cmd.base) begin
      base_m <= row - plane;
      base_p <= row + plane;
    end
  end

  // neighbour scan, dz then dy then dx
  always_ff @(posedge clk) begin
    if (rst) begin
      cdx <= OFF_NEG;
      cdy <= OFF_NEG;
      cdz <= OFF_NEG;
    end else if (cmd.base) begin
      cdx <= OFF_NEG;
      cdy <= OFF_NEG;
      cdz <= OFF_NEG;
    end else if (cmd.emit) begin
      if (cdx != OFF_POS) begin
        cdx <= off_t'(cdx + 2'd1);
      end else begin
        cdx <= OFF_NEG;
        if (cdy != OFF_POS) begin
          cdy <= off_t'(cdy + 2'd1);
        end else begin
          cdy <= OFF_NEG;
          cdz <= off_t'(cdz + 2'd1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit && cand_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && cand_valid) begin
      out_row  <= row;
      out_col  <= col;
      out_coef <= coef;
      out_last <= status.cand_last;
      out_grid <= status.cand_last && last_point;
    end
  end

  assign m_tdata    = {2'b00, out_coef, out_col, out_row};
  assign m_tlast    = out_last;
  assign m_tuser[0] = out_grid;

  a_last_is_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!status.cand_last || cand_valid))
    else $error("last neighbour of a row lies outside the grid");

  a_grid_done_ends_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("grid end flagged on an entry that does not end its row");

  a_point_in_grid: assert property (@(posedge clk) disable iff (rst)
    cmd.advance |=> (EW'(px) < nx) && (EW'(py) < ny) && (EW'(pz) < nz))
    else $error("scan point left the grid");

endmodule

/* tb/sv/stencil27_matrix_row_generator_tb.sv */
`timescale 1ns / 100ps

module stencil27_matrix_row_generator_tb;
  import s27g_pkg::*;

  localparam int Q12_ONE = 4096;
  localparam int STALL_LIMIT = 3000;
  localparam int ROW_LSB = 0;
  localparam int COL_LSB = IDX_W;
  localparam int COEF_LSB = 2 * IDX_W;
  localparam int RANDOM_ROWS = 245;

  typedef struct packed {
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [COEF_W-1:0] coef;
    logic                     row_done;
    logic                     grid_done;
  } stencil_entry_t;

  // tracks the scan position and predicts every entry of each requested row
  class stencil_row_tracker;
    logic [SIZE_W-1:0] dim_x, dim_y, dim_z;
    logic signed [BETA_W-1:0] beta_q12;
    longint pos_x, pos_y, pos_z;
    stencil_entry_t expected_entries[$];
    int unsigned rows_checked;
    int unsigned entries_checked;
    int unsigned grid_wraps;
    int unsigned errors;

    function new();
      dim_x = SIZE_RESET;
      dim_y = SIZE_RESET;
      dim_z = SIZE_RESET;
      beta_q12 = BETA_RESET;
      pos_x = 0;
      pos_y = 0;
      pos_z = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [BETA_W-1:0] val);
      case (idx)
        REG_SIZE_X: dim_x = val[SIZE_W-1:0];
        REG_SIZE_Y: dim_y = val[SIZE_W-1:0];
        REG_SIZE_Z: dim_z = val[SIZE_W-1:0];
        REG_BETA:   beta_q12 = val;
        default: ;
      endcase
    endfunction

    // zero counts as one, anything past the grid limit is clamped
    function longint eff_size(logic [SIZE_W-1:0] r);
      if (r == 0) return 1;
      if (r > 1024) return 1024;
      return r;
    endfunction

    function void note_row(logic restart);
      longint nx, ny, nz, row, col, cx, cy, cz;
      int c;
      logic last_pt;
      stencil_entry_t e;
      stencil_entry_t row_q[$];
      nx = eff_size(dim_x);
      ny = eff_size(dim_y);
      nz = eff_size(dim_z);
      if (restart || pos_x >= nx || pos_y >= ny || pos_z >= nz) begin
        pos_x = 0;
        pos_y = 0;
        pos_z = 0;
      end
      row = pos_z * nx * ny + pos_y * nx + pos_x;
      last_pt = (pos_x == nx - 1) && (pos_y == ny - 1) && (pos_z == nz - 1);
      for (int dz = -1; dz <= 1; dz++) begin
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            cx = pos_x + dx;
            cy = pos_y + dy;
            cz = pos_z + dz;
            if (cx < 0 || cy < 0 || cz < 0) continue;
            if (cx >= nx || cy >= ny || cz >= nz) continue;
            col = cz * nx * ny + cy * nx + cx;
            if (dx == 0 && dy == 0 && dz == 0) c = 26 * Q12_ONE;
            else if (dx == 0 && dy == 0 && dz < 0) c = -Q12_ONE - int'(beta_q12);
            else if (dx == 0 && dy == 0) c = -Q12_ONE + int'(beta_q12);
            else c = -Q12_ONE;
            e.row_index = IDX_W'(row + 1);
            e.col_index = IDX_W'(col + 1);
            e.coef = COEF_W'(c);
            e.row_done = 1'b0;
            e.grid_done = 1'b0;
            row_q.push_back(e);
          end
        end
      end
      row_q[row_q.size()-1].row_done = 1'b1;
      row_q[row_q.size()-1].grid_done = last_pt;
      foreach (row_q[i]) expected_entries.push_back(row_q[i]);
      if (pos_x + 1 < nx) begin
        pos_x++;
      end else begin
        pos_x = 0;
        if (pos_y + 1 < ny) begin
          pos_y++;
        end else begin
          pos_y = 0;
          if (pos_z + 1 < nz) pos_z++;
          else pos_z = 0;
        end
      end
    endfunction

    function void check_entry(logic [OUT_DATA_W-1:0] data, logic last, logic gdone);
      stencil_entry_t e;
      logic [IDX_W-1:0] got_row, got_col;
      logic signed [COEF_W-1:0] got_coef;
      got_row = data[ROW_LSB +: IDX_W];
      got_col = data[COL_LSB +: IDX_W];
      got_coef = data[COEF_LSB +: COEF_W];
      if (expected_entries.size() == 0) begin
        $error("entry with nothing pending: row_index %0d col_index %0d", got_row, got_col);
        errors++;
        return;
      end
      e = expected_entries.pop_front();
      entries_checked++;
      if (e.row_done) rows_checked++;
      if (e.grid_done) grid_wraps++;
      if (got_row !== e.row_index) begin
        $error("row_index: expected %0d, actual %0d", e.row_index, got_row);
        errors++;
      end
      if (got_col !== e.col_index) begin
        $error("col_index: expected %0d, actual %0d", e.col_index, got_col);
        errors++;
      end
      if (got_coef !== e.coef) begin
        $error("coef: expected %0d, actual %0d", e.coef, got_coef);
        errors++;
      end
      if (last !== e.row_done) begin
        $error("row_done: expected %0b, actual %0b", e.row_done, last);
        errors++;
      end
      if (gdone !== e.grid_done) begin
        $error("grid_done: expected %0b, actual %0b", e.grid_done, gdone);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = REG_SIZE_X;
  logic [BETA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tlast;
  logic [0:0] m_tuser;

  stencil_row_tracker tracker = new();
  int unsigned rows_sent = 0;
  int unsigned settings_used = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  logic tx_steady = 1'b1;
  logic rx_steady = 1'b1;
  logic [15:0] stall_mask = 16'hFFFF;
  logic [3:0] stall_phase = '0;

  stencil27_matrix_row_generator #(
    .DIM_BITS(10)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(reg_idx_t'(cfg_index), cfg_data);
      if (s_tvalid && s_tready) tracker.note_row(s_tdata[0]);
      if (m_tvalid && m_tready) tracker.check_entry(m_tdata, m_tlast, m_tuser[0]);
    end
  end

  always @(posedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    if (rx_steady) m_tready <= 1'b1;
    else m_tready <= stall_mask[stall_phase] | ($urandom_range(0, 7) == 0);
  end

  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $error("no transaction for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_row(input logic restart);
    int unsigned gap;
    if (burst_left == 0) begin
      if (tx_steady) gap = 0;
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(8, 40);
      else gap = $urandom_range(0, 4);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_DATA_W-1){1'b0}}, restart};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    rows_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (tracker.rows_checked != rows_sent) @(posedge clk);
  endtask

  task automatic configure(input logic [BETA_W-1:0] sx, input logic [BETA_W-1:0] sy,
                           input logic [BETA_W-1:0] sz, input logic [BETA_W-1:0] beta);
    reg_idx_t order[4];
    logic [BETA_W-1:0] vals[4];
    order = '{REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z, REG_BETA};
    vals = '{sx, sy, sz, beta};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [BETA_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 13) return BETA_W'($urandom_range(1, 4));
    if (r < 17) return BETA_W'($urandom_range(5, 12));
    case ($urandom_range(0, 3))
      0: return '0;
      1: return BETA_W'(1024);
      2: return {5'($urandom), 11'h7FF};
      default: return BETA_W'($urandom);
    endcase
  endfunction

  function automatic logic [BETA_W-1:0] pick_beta();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return '0;
      default: return BETA_W'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned n;
    int unsigned mode;
    int unsigned phase;
    int unsigned target;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, then a restart back to the first point
    repeat (3) send_row(1'b0);
    send_row(1'b1);
    // single point grid, largest beta
    configure(16'd1, 16'd1, 16'd1, 16'h7FFF);
    repeat (2) send_row(1'b0);
    // zero sizes act as one, most negative beta
    configure(16'd0, 16'd0, 16'd0, 16'h8000);
    send_row(1'b0);
    send_row(1'b1);
    // walk up to the fully interior point
    configure(16'd3, 16'd3, 16'd3, 16'h0000);
    repeat (14) send_row(1'b0);
    // oversized grid clamps to the limit
    configure(16'hFFFF, 16'h0400, 16'h07FF, 16'h1000);
    repeat (2) send_row(1'b0);
    // shrinking x leaves the held point outside the grid
    configure(16'd2, 16'h0400, 16'h0400, 16'hF000);
    send_row(1'b0);

    target = rows_sent + RANDOM_ROWS;
    phase = 0;
    while (rows_sent < target) begin
      mode = $urandom_range(0, 3);
      tx_steady = (mode == 0 || mode == 2);
      rx_steady <= (mode == 0 || mode == 1);
      stall_mask <= 16'($urandom);
      configure(pick_size(), pick_size(), pick_size(), pick_beta());
      n = $urandom_range(8, 40);
      for (int i = 0; i < n && rows_sent < target; i++) begin
        if (i == n / 2 && (phase == 0 || $urandom_range(0, 3) == 0)) drain();
        send_row($urandom_range(0, 15) == 0);
      end
      phase++;
    end

    drain();
    repeat (40) @(posedge clk);
    if (tracker.expected_entries.size() != 0) begin
      $error("%0d entries never arrived", tracker.expected_entries.size());
      tracker.errors++;
    end
    $display("covered %0d rows and %0d entries over %0d grid and beta settings",
             rows_sent, tracker.entries_checked, settings_used + 1);
    $display("grid end reached %0d times, with restarts and random stalls on both sides",
             tracker.grid_wraps);
    if (tracker.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

/* stencil27_matrix_row_generator.f */
rtl/core/s27g_pkg.sv
rtl/core/s27g_ctrl.sv
rtl/core/s27g_dp.sv
rtl/core/stencil27_matrix_row_generator.sv
tb/sv/stencil27_matrix_row_generator_tb.sv
